// ===== src/assert_macros.svh =====
// assertion helpers, clocked on clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cst_pkg.sv =====
package cst_pkg;

  localparam int MAX_AM_DEF    = 6;
  localparam int MAX_COEFS_DEF = 128;

  localparam logic [63:0] FP_DNAN = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] FP_QBIT = 64'h0008_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_LOADC = 2'd0,
    OP_LOADB = 2'd1,
    OP_RUN   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_ROW_AM    = 3'd0,
    CFG_COL_AM    = 3'd1,
    CFG_ROW_SPH   = 3'd2,
    CFG_COL_SPH   = 3'd3,
    CFG_ROW_COUNT = 3'd4,
    CFG_COL_COUNT = 3'd5
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CCLR, S_CIDX, S_CDEC, S_CCPR, S_CCPW,
    S_RCLR, S_RIDX, S_RDEC, S_RQRD, S_RCPR, S_RCPW,
    S_MUL, S_MULW, S_ADD, S_ADDW, S_DONE
  } run_state_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_ALIGN, F_NORM, F_RND
  } fpu_state_t;

  typedef struct packed {
    logic start;
    logic add;
  } fpu_req_t;

endpackage

// ===== src/cartesian_to_spherical_transform.sv =====
// cartesian to spherical transform of one shell-pair block of doubles
//
// input words: start with busy low accepts a word; op picks the command.
//   load coefficient (op 0) and load element (op 1) leave busy low and
//   give no result. read (op 3) gives its element one cycle after accept,
//   and a new word may be taken in that same cycle: one word per cycle.
//   run (op 2) holds busy high while it walks the stores, then shows a
//   done word (done_res high) for one cycle and drops busy.
// run steps: each coefficient step is a read-modify-write of a store
//   entry through the shared float unit (multiply then add), slower for
//   subnormal operands, where the normalizer shifts one bit per cycle.
//   clears write each grid entry in a single state; copies read each
//   entry in one state and write it in the next.
// results: valid marks a result for exactly one cycle; the receiver takes
//   it then and cannot stall it.
// cfg_we writes cfg_data to register cfg_idx; user: idle only, unchecked.
// reset: synchronous rst clears the sequencer and the config registers;
//   the stores are not cleared and hold garbage until written.
`include "assert_macros.svh"

module cartesian_to_spherical_transform import cst_pkg::*; #(
  parameter int MAX_AM    = MAX_AM_DEF,
  parameter int MAX_COEFS = MAX_COEFS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic        side,
  input  logic [6:0]  entry,
  input  logic [4:0]  cart_pos,
  input  logic [3:0]  pure_pos,
  input  logic [63:0] coef_bits,
  input  logic [4:0]  row,
  input  logic [4:0]  col,
  input  logic [63:0] value_bits,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [7:0]  cfg_data,
  output logic        valid,
  output logic [4:0]  out_row,
  output logic [4:0]  out_col,
  output logic [63:0] out_bits,
  output logic        done_res
);

  localparam int NCMAX = (MAX_AM + 1) * (MAX_AM + 2) / 2;
  localparam int NSQ   = NCMAX * NCMAX;
  localparam int AW    = $clog2(NSQ);
  localparam int PW    = $clog2(NCMAX + 1);
  localparam int KW    = $clog2(MAX_COEFS + 1);
  localparam int CW    = $clog2(2 * MAX_COEFS);

  // config registers
  logic [2:0] row_am, col_am;
  logic       row_spherical, col_spherical;
  logic [7:0] row_coef_count, col_coef_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_am         <= 3'd0;
      col_am         <= 3'd0;
      row_spherical  <= 1'b1;
      col_spherical  <= 1'b1;
      row_coef_count <= 8'd0;
      col_coef_count <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_ROW_AM:    row_am         <= cfg_data[2:0];
        CFG_COL_AM:    col_am         <= cfg_data[2:0];
        CFG_ROW_SPH:   row_spherical  <= cfg_data[0];
        CFG_COL_SPH:   col_spherical  <= cfg_data[0];
        CFG_ROW_COUNT: row_coef_count <= cfg_data;
        CFG_COL_COUNT: col_coef_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // shell sizes from the saturated angular momenta
  logic [3:0]    l1, l2;
  logic [PW-1:0] nc1, nc2, np1, np2, nf2;
  logic [KW-1:0] nrow, ncol;
  logic          col_tr, row_tr;

  assign l1   = ({1'b0, row_am} > 4'(MAX_AM)) ? 4'(MAX_AM) : {1'b0, row_am};
  assign l2   = ({1'b0, col_am} > 4'(MAX_AM)) ? 4'(MAX_AM) : {1'b0, col_am};
  assign nc1  = PW'(((int'(l1) + 1) * (int'(l1) + 2)) >> 1);
  assign nc2  = PW'(((int'(l2) + 1) * (int'(l2) + 2)) >> 1);
  assign np1  = PW'(2 * int'(l1) + 1);
  assign np2  = PW'(2 * int'(l2) + 1);
  assign nf2  = col_spherical ? np2 : nc2;
  assign nrow = KW'((int'(row_coef_count) > MAX_COEFS) ? MAX_COEFS : int'(row_coef_count));
  assign ncol = KW'((int'(col_coef_count) > MAX_COEFS) ? MAX_COEFS : int'(col_coef_count));
  assign col_tr = col_spherical && (l2 != 4'd0);
  assign row_tr = row_spherical && (l1 != 4'd0);

  function automatic logic [AW-1:0] grid(input logic [PW-1:0] i, input logic [PW-1:0] j);
    return AW'(int'(i) * NCMAX + int'(j));
  endfunction

  // stores
  logic [63:0] block_mem   [NSQ];
  logic [63:0] scratch_mem [NSQ];
  logic [63:0] coef_mem    [2*MAX_COEFS];
  logic [8:0]  index_mem   [2*MAX_COEFS];

  logic          blk_re, blk_we, scr_re, scr_we, cf_re, cf_we;
  logic [AW-1:0] blk_raddr, blk_waddr, scr_raddr, scr_waddr;
  logic [63:0]   blk_wdata, scr_wdata, blk_q, scr_q, coef_q, cf_wdata;
  logic [CW-1:0] cf_raddr, cf_waddr;
  logic [8:0]    ix_wdata, ix_q;

  always_ff @(posedge clk) begin
    if (blk_we) block_mem[blk_waddr] <= blk_wdata;
    if (blk_re) blk_q <= block_mem[blk_raddr];
  end

  always_ff @(posedge clk) begin
    if (scr_we) scratch_mem[scr_waddr] <= scr_wdata;
    if (scr_re) scr_q <= scratch_mem[scr_raddr];
  end

  always_ff @(posedge clk) begin
    if (cf_we) begin
      coef_mem[cf_waddr]  <= cf_wdata;
      index_mem[cf_waddr] <= ix_wdata;
    end
    if (cf_re) begin
      coef_q <= coef_mem[cf_raddr];
      ix_q   <= index_mem[cf_raddr];
    end
  end

  // float unit, shared by every multiply and accumulate
  fpu_req_t    fpu_req;
  logic [63:0] fpu_a, fpu_b, fpu_res;
  logic        fpu_done;

  cst_fpu u_fpu (
    .clk  (clk),
    .rst  (rst),
    .req  (fpu_req),
    .a    (fpu_a),
    .b    (fpu_b),
    .done (fpu_done),
    .res  (fpu_res)
  );

  // sequencer
  run_state_t    state, state_next;
  logic [PW-1:0] p, p_next, q, q_next, rc, rc_next, rs, rs_next;
  logic [KW-1:0] k, k_next;
  logic          rowph, rowph_next;
  logic [AW-1:0] acc_addr, acc_addr_next;
  logic [63:0]   prod, prod_next;

  logic          accept, in_range;
  logic [4:0]    ix_c;
  logic [3:0]    ix_s;
  run_state_t    row_entry;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign in_range  = (int'(row) < NCMAX) && (int'(col) < NCMAX);
  assign ix_c      = ix_q[4:0];
  assign ix_s      = ix_q[8:5];
  assign row_entry = row_tr ? S_RCLR : S_RCPR;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      p     <= '0;
      q     <= '0;
      k     <= '0;
      rowph <= 1'b0;
    end else begin
      state <= state_next;
      p     <= p_next;
      q     <= q_next;
      k     <= k_next;
      rowph <= rowph_next;
    end
  end

  always_ff @(posedge clk) begin
    rc       <= rc_next;
    rs       <= rs_next;
    acc_addr <= acc_addr_next;
    prod     <= prod_next;
  end

  always_comb begin
    state_next    = state;
    p_next        = p;
    q_next        = q;
    k_next        = k;
    rowph_next    = rowph;
    rc_next       = rc;
    rs_next       = rs;
    acc_addr_next = acc_addr;
    prod_next     = prod;
    blk_re        = 1'b0;
    blk_raddr     = grid(p, q);
    blk_we        = 1'b0;
    blk_waddr     = grid(p, q);
    blk_wdata     = 64'd0;
    scr_re        = 1'b0;
    scr_raddr     = grid(p, q);
    scr_we        = 1'b0;
    scr_waddr     = grid(p, q);
    scr_wdata     = 64'd0;
    cf_re         = 1'b0;
    cf_raddr      = CW'(k);
    cf_we         = 1'b0;
    cf_waddr      = CW'(side ? MAX_COEFS : 0) + CW'(entry);
    cf_wdata      = coef_bits;
    ix_wdata      = {pure_pos, cart_pos};
    fpu_req       = '0;
    fpu_a         = coef_q;
    fpu_b         = rowph ? scr_q : blk_q;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(op))
            OP_LOADC: cf_we = (int'(entry) < MAX_COEFS);
            OP_LOADB: begin
              blk_we    = in_range;
              blk_waddr = grid(PW'(row), PW'(col));
              blk_wdata = value_bits;
            end
            OP_RUN: begin
              p_next     = '0;
              q_next     = '0;
              k_next     = '0;
              rowph_next = 1'b0;
              if (!row_spherical && !col_spherical) begin
                state_next = S_DONE;
              end else if (col_tr) begin
                state_next = S_CCLR;
              end else begin
                state_next = S_CCPR;
              end
            end
            OP_READ: begin
              blk_re    = in_range;
              blk_raddr = grid(PW'(row), PW'(col));
            end
            default: ;
          endcase
        end
      end

      // column side: scratch row p gets sum over coefficients of block row p
      S_CCLR: begin
        scr_we = 1'b1;
        if (q == np2 - 1'b1) begin
          q_next     = '0;
          k_next     = '0;
          state_next = S_CIDX;
        end else begin
          q_next = q + 1'b1;
        end
      end
      S_CIDX: begin
        if (k == ncol) begin
          if (p == nc1 - 1'b1) begin
            state_next = row_entry;
            p_next     = '0;
            q_next     = '0;
            k_next     = '0;
            rowph_next = 1'b1;
          end else begin
            p_next     = p + 1'b1;
            q_next     = '0;
            state_next = S_CCLR;
          end
        end else begin
          cf_re      = 1'b1;
          cf_raddr   = CW'(MAX_COEFS) + CW'(k);
          state_next = S_CDEC;
        end
      end
      S_CDEC: begin
        if ((int'(ix_c) >= int'(nc2)) || (int'(ix_s) >= int'(np2))) begin
          k_next     = k + 1'b1;
          state_next = S_CIDX;
        end else begin
          blk_re        = 1'b1;
          blk_raddr     = grid(p, PW'(ix_c));
          scr_re        = 1'b1;
          scr_raddr     = grid(p, PW'(ix_s));
          acc_addr_next = grid(p, PW'(ix_s));
          state_next    = S_MUL;
        end
      end
      S_CCPR: begin
        blk_re     = 1'b1;
        state_next = S_CCPW;
      end
      S_CCPW: begin
        scr_we    = 1'b1;
        scr_wdata = blk_q;
        if (q == nc2 - 1'b1) begin
          q_next = '0;
          if (p == nc1 - 1'b1) begin
            state_next = row_entry;
            p_next     = '0;
            k_next     = '0;
            rowph_next = 1'b1;
          end else begin
            p_next     = p + 1'b1;
            state_next = S_CCPR;
          end
        end else begin
          q_next     = q + 1'b1;
          state_next = S_CCPR;
        end
      end

      // row side: each coefficient adds a scaled scratch row into a block row
      S_RCLR: begin
        blk_we = 1'b1;
        if (q == nf2 - 1'b1) begin
          q_next = '0;
          if (p == np1 - 1'b1) begin
            k_next     = '0;
            state_next = S_RIDX;
          end else begin
            p_next = p + 1'b1;
          end
        end else begin
          q_next = q + 1'b1;
        end
      end
      S_RIDX: begin
        if (k == nrow) begin
          state_next = S_DONE;
        end else begin
          cf_re      = 1'b1;
          state_next = S_RDEC;
        end
      end
      S_RDEC: begin
        if ((int'(ix_c) >= int'(nc1)) || (int'(ix_s) >= int'(np1))) begin
          k_next     = k + 1'b1;
          state_next = S_RIDX;
        end else begin
          rc_next    = PW'(ix_c);
          rs_next    = PW'(ix_s);
          q_next     = '0;
          state_next = S_RQRD;
        end
      end
      S_RQRD: begin
        scr_re        = 1'b1;
        scr_raddr     = grid(rc, q);
        blk_re        = 1'b1;
        blk_raddr     = grid(rs, q);
        acc_addr_next = grid(rs, q);
        state_next    = S_MUL;
      end
      S_RCPR: begin
        scr_re     = 1'b1;
        state_next = S_RCPW;
      end
      S_RCPW: begin
        blk_we    = 1'b1;
        blk_wdata = scr_q;
        if (q == nf2 - 1'b1) begin
          q_next = '0;
          if (p == nc1 - 1'b1) begin
            state_next = S_DONE;
          end else begin
            p_next     = p + 1'b1;
            state_next = S_RCPR;
          end
        end else begin
          q_next     = q + 1'b1;
          state_next = S_RCPR;
        end
      end

      // shared multiply then accumulate, written back to acc_addr
      S_MUL: begin
        fpu_req.start = 1'b1;
        state_next    = S_MULW;
      end
      S_MULW: begin
        if (fpu_done) begin
          prod_next  = fpu_res;
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        fpu_req.start = 1'b1;
        fpu_req.add   = 1'b1;
        fpu_a         = rowph ? blk_q : scr_q;
        fpu_b         = prod;
        state_next    = S_ADDW;
      end
      S_ADDW: begin
        if (fpu_done) begin
          if (rowph) begin
            blk_we    = 1'b1;
            blk_waddr = acc_addr;
            blk_wdata = fpu_res;
            if (q == nf2 - 1'b1) begin
              q_next     = '0;
              k_next     = k + 1'b1;
              state_next = S_RIDX;
            end else begin
              q_next     = q + 1'b1;
              state_next = S_RQRD;
            end
          end else begin
            scr_we     = 1'b1;
            scr_waddr  = acc_addr;
            scr_wdata  = fpu_res;
            k_next     = k + 1'b1;
            state_next = S_CIDX;
          end
        end
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // read response, registered in the cycle after its accept
  logic       rd_pend, rd_inr;
  logic [4:0] rd_row, rd_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= accept && (op == OP_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_inr <= in_range;
      rd_row <= row;
      rd_col <= col;
    end
  end

  assign done_res = (state == S_DONE);
  assign valid    = rd_pend || done_res;
  assign out_row  = rd_pend ? rd_row : 5'd0;
  assign out_col  = rd_pend ? rd_col : 5'd0;
  assign out_bits = (rd_pend && rd_inr) ? blk_q : 64'd0;

  `ASSERT_NEXT(a_read_resp, accept && (op == OP_READ), valid && !done_res, "read word lost")
  `ASSERT_NEXT(a_load_quiet, accept && (op == OP_LOADC || op == OP_LOADB), !valid, "load gave a word")
  `ASSERT_NEXT(a_run_busy, accept && (op == OP_RUN), busy, "run did not hold busy")
  `ASSERT_NEXT(a_done_idle, valid && done_res, !busy, "busy after done word")

endmodule

// ===== src/cst_fpu.sv =====
module cst_fpu import cst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  fpu_req_t    req,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] res
);

  fpu_state_t fstate, fstate_next;

  logic               sign;
  logic               sub;
  logic signed [13:0] ex;
  logic [107:0]       mm;
  logic [52:0]        ma, mb;
  logic [52:0]        big_m, small_m;
  logic [10:0]        dshift;
  logic [105:0]       acc;
  logic [53:0]        pp;
  logic [1:0]         pp_sh;
  logic [2:0]         cnt;

  // operand decode
  logic [10:0] ea_f, eb_f, ea_n, eb_n;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_big;
  logic        spec;
  logic [63:0] spec_val;

  assign ea_f   = a[62:52];
  assign eb_f   = b[62:52];
  assign ea_n   = (ea_f == 11'd0) ? 11'd1 : ea_f;
  assign eb_n   = (eb_f == 11'd0) ? 11'd1 : eb_f;
  assign a_nan  = (ea_f == 11'h7FF) && (a[51:0] != 52'd0);
  assign b_nan  = (eb_f == 11'h7FF) && (b[51:0] != 52'd0);
  assign a_inf  = (ea_f == 11'h7FF) && (a[51:0] == 52'd0);
  assign b_inf  = (eb_f == 11'h7FF) && (b[51:0] == 52'd0);
  assign a_zero = (a[62:0] == 63'd0);
  assign b_zero = (b[62:0] == 63'd0);
  assign a_big  = (a[62:0] >= b[62:0]);

  always_comb begin
    spec     = 1'b1;
    spec_val = 64'd0;
    if (a_nan) begin
      spec_val = a | FP_QBIT;
    end else if (b_nan) begin
      spec_val = b | FP_QBIT;
    end else if (!req.add) begin
      if ((a_inf && b_zero) || (b_inf && a_zero)) begin
        spec_val = FP_DNAN;
      end else if (a_inf || b_inf) begin
        spec_val = {a[63] ^ b[63], 11'h7FF, 52'd0};
      end else begin
        spec = 1'b0;
      end
    end else begin
      if (a_inf && b_inf && (a[63] != b[63])) begin
        spec_val = FP_DNAN;
      end else if (a_inf) begin
        spec_val = a;
      end else if (b_inf) begin
        spec_val = b;
      end else begin
        spec = 1'b0;
      end
    end
  end

  // partial products, 27 x 27 each
  logic [26:0]  mul_x, mul_y;
  logic [53:0]  pp_now;
  logic [105:0] pp_ext, acc_sum;

  assign mul_x  = cnt[1] ? {1'b0, ma[52:27]} : ma[26:0];
  assign mul_y  = cnt[0] ? {1'b0, mb[52:27]} : mb[26:0];
  assign pp_now = mul_x * mul_y;

  always_comb begin
    case (pp_sh)
      2'd1:    pp_ext = {25'd0, pp, 27'd0};
      2'd2:    pp_ext = {pp[51:0], 54'd0};
      default: pp_ext = {52'd0, pp};
    endcase
    acc_sum = acc + pp_ext;
  end

  // alignment with sticky for the smaller addend
  logic [107:0] afull, bfull, bsh, sum;
  logic         lost;

  always_comb begin
    afull = {1'b0, big_m, 54'd0};
    bfull = {1'b0, small_m, 54'd0};
    lost  = |(bfull & ~({108{1'b1}} << dshift));
    if (dshift >= 11'd108) begin
      bsh = {107'd0, |small_m};
    end else begin
      bsh = (bfull >> dshift) | {107'd0, lost};
    end
    sum = sub ? (afull - bsh) : (afull + bsh);
  end

  // rounding, nearest even; the add carries into the exponent field
  logic [62:0] field;
  logic        rnd_up;

  assign field  = {(mm[107] ? ex[10:0] : 11'd0), mm[106:55]};
  assign rnd_up = mm[54] & ((|mm[53:0]) | mm[55]);

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
    end else begin
      fstate <= fstate_next;
    end
  end

  always_comb begin
    fstate_next = fstate;
    case (fstate)
      F_IDLE: begin
        if (req.start && !spec) begin
          fstate_next = req.add ? F_ALIGN : F_MUL;
        end
      end
      F_MUL: begin
        if (cnt == 3'd4) begin
          fstate_next = F_NORM;
        end
      end
      F_ALIGN: fstate_next = F_NORM;
      F_NORM: begin
        if (mm == 108'd0) begin
          fstate_next = F_IDLE;
        end else if (ex < 14'sd1) begin
          fstate_next = F_NORM;
        end else if (!mm[107] && (ex > 14'sd1)) begin
          fstate_next = F_NORM;
        end else begin
          fstate_next = F_RND;
        end
      end
      F_RND:   fstate_next = F_IDLE;
      default: fstate_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (fstate)
        F_IDLE: begin
          if (req.start) begin
            if (spec) begin
              done <= 1'b1;
              res  <= spec_val;
            end else if (!req.add) begin
              sign  <= a[63] ^ b[63];
              ma    <= {ea_f != 11'd0, a[51:0]};
              mb    <= {eb_f != 11'd0, b[51:0]};
              ex    <= $signed({3'b000, ea_n}) + $signed({3'b000, eb_n}) - 14'sd1022;
              acc   <= 106'd0;
              cnt   <= 3'd0;
              pp_sh <= 2'd0;
            end else begin
              sub <= a[63] ^ b[63];
              if (a_big) begin
                sign    <= a[63];
                big_m   <= {ea_f != 11'd0, a[51:0]};
                small_m <= {eb_f != 11'd0, b[51:0]};
                dshift  <= ea_n - eb_n;
                ex      <= $signed({3'b000, ea_n}) + 14'sd1;
              end else begin
                sign    <= b[63];
                big_m   <= {eb_f != 11'd0, b[51:0]};
                small_m <= {ea_f != 11'd0, a[51:0]};
                dshift  <= eb_n - ea_n;
                ex      <= $signed({3'b000, eb_n}) + 14'sd1;
              end
            end
          end
        end
        F_MUL: begin
          if (cnt != 3'd4) begin
            pp    <= pp_now;
            pp_sh <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
          end
          if (cnt != 3'd0) begin
            acc <= acc_sum;
          end
          if (cnt == 3'd4) begin
            mm <= {acc_sum, 2'b00};
          end
          cnt <= cnt + 3'd1;
        end
        F_ALIGN: begin
          mm <= sum;
          if (sub && (sum == 108'd0)) begin
            sign <= 1'b0;
          end
        end
        F_NORM: begin
          if (mm == 108'd0) begin
            done <= 1'b1;
            res  <= {sign, 63'd0};
          end else if (ex < 14'sd1) begin
            if (ex < -14'sd110) begin
              mm <= {107'd0, 1'b1};
              ex <= 14'sd1;
            end else begin
              mm <= {1'b0, mm[107:2], mm[1] | mm[0]};
              ex <= ex + 14'sd1;
            end
          end else if (!mm[107] && (ex > 14'sd1)) begin
            mm <= {mm[106:0], 1'b0};
            ex <= ex - 14'sd1;
          end
        end
        F_RND: begin
          done <= 1'b1;
          if (ex > 14'sd2046) begin
            res <= {sign, 11'h7FF, 52'd0};
          end else begin
            res <= {sign, field + {62'd0, rnd_up}};
          end
        end
        default: ;
      endcase
    end
  end

endmodule
